>>> hw/rtl/kdr_pkg.sv
// Package for the K-line diagnostic read engine.
// Operation, phase, deframer and verdict codes, request constants, register indexes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kdr_pkg;

  localparam int unsigned TickBits = 16;

  typedef enum logic [1:0] {
    OpStart = 2'd0,
    OpByte  = 2'd1,
    OpTick  = 2'd2,
    OpRsvd  = 2'd3
  } op_e;

  typedef enum logic {
    PhIdle = 1'b0,
    PhWait = 1'b1
  } phase_e;

  typedef enum logic [2:0] {
    DfHunt = 3'd0,
    DfF0   = 3'd1,
    Df10   = 3'd2,
    DfLen  = 3'd3,
    DfPay  = 3'd4,
    DfCks  = 3'd5
  } dfpos_e;

  typedef enum logic [2:0] {
    VerdOk       = 3'd0,
    VerdTimeout  = 3'd1,
    VerdChecksum = 3'd2,
    VerdShort    = 3'd3,
    VerdStatus   = 3'd4
  } verdict_e;

  typedef enum logic {
    KindTx      = 1'b0,
    KindVerdict = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    CfgDataLength  = 2'd0,
    CfgValueSigned = 2'd1,
    CfgDelay       = 2'd2,
    CfgTimeout     = 2'd3
  } cfg_idx_e;

  localparam logic [7:0] HdrSync  = 8'h80;
  localparam logic [7:0] HdrDst   = 8'hF0;
  localparam logic [7:0] HdrSrc   = 8'h10;
  localparam logic [7:0] StatusOk = 8'hE8;

  localparam logic [7:0] ReqHeader [8] = '{
    8'h80, 8'h10, 8'hF0, 8'h05, 8'hA8, 8'h00, 8'h00, 8'h00
  };

  // mod-256 sum of the fixed request bytes
  localparam logic [7:0] ReqSumBase = 8'(32'h80 + 32'h10 + 32'hF0 + 32'h05 + 32'hA8);

  localparam logic [3:0] ReqLastIdx = 4'd9;
  localparam logic [3:0] ReqAddrIdx = 4'd8;

endpackage

`default_nettype wire

>>> hw/rtl/kdr_if.sv
// Valid/ready channel interfaces of the K-line read engine.
// Input item channel and result channel; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface kdr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] param_address;
  logic [7:0] rx_byte;

  modport source (output valid, output operation, output param_address, output rx_byte,
                  input ready);
  modport sink (input valid, input operation, input param_address, input rx_byte,
                output ready);
endinterface

interface kdr_out_if;
  logic               valid;
  logic               ready;
  logic               result_kind;
  logic [7:0]         tx_byte;
  logic               tx_last;
  logic [2:0]         verdict_code;
  logic [7:0]         read_address;
  logic signed [32:0] raw_value;

  modport source (output valid, output result_kind, output tx_byte, output tx_last,
                  output verdict_code, output read_address, output raw_value,
                  input ready);
  modport sink (input valid, input result_kind, input tx_byte, input tx_last,
                input verdict_code, input read_address, input raw_value,
                output ready);
endinterface

`default_nettype wire

>>> hw/rtl/kline_diag_read_engine_unit.sv
// K-line diagnostic single-address read engine, top level.
// Depends on kdr_pkg and the channel interfaces in kdr_if.sv.
//
//   channel  | dir | handshake    | carries
//   in_i     | in  | valid/ready  | operation, param_address, rx_byte
//   out_o    | out | valid/ready  | result_kind, tx_byte, tx_last, verdict_code,
//            |     |              | read_address, raw_value
//   cfg      | in  | cfg_we_i     | cfg_index_i, cfg_data_i
//
// One item per cycle while no request run is under way and the result register is free or being drained.
// A start item yields ten request bytes; the input is held off while the result register
// sends the rest, also through output stalls.
// Bytes and ticks finish in the cycle they are accepted; a verdict is one result.
// Async active-low reset: idle, registers at their defaults, no result pending.
`timescale 1ns / 1ps
`default_nettype none

module kline_diag_read_engine_unit (
  input  wire         clk_i,
  input  wire         rst_ni,
  kdr_in_if.sink      in_i,
  kdr_out_if.source   out_o,
  input  wire         cfg_we_i,
  input  wire  [1:0]  cfg_index_i,
  input  wire  [15:0] cfg_data_i
);
  import kdr_pkg::*;

  // configuration
  logic [2:0]  data_length_q;
  logic        value_signed_q;
  logic [15:0] delay_q;
  logic [15:0] timeout_q;

  // engine state
  phase_e                phase_q, phase_d;
  logic [TickBits-1:0]   elapsed_q, elapsed_d;
  logic [7:0]            addr_q, addr_d;
  dfpos_e                dfpos_q, dfpos_d;
  logic [7:0]            plen_q, plen_d;
  logic [7:0]            pcnt_q, pcnt_d;
  logic [7:0]            sum_q, sum_d;
  logic [7:0]            status_q, status_d;
  logic [31:0]           acc_q, acc_d;
  logic [2:0]            cap_q, cap_d;
  logic                  pend_q, pend_d;
  verdict_e              pcode_q, pcode_d;
  logic                  burst_q, burst_d;
  logic [3:0]            bidx_q, bidx_d;

  // result register
  logic                  ovalid_q, ovalid_d;
  kind_e                 okind_q, okind_d;
  logic [7:0]            otx_q, otx_d;
  logic                  olast_q, olast_d;
  verdict_e              ocode_q, ocode_d;
  logic [7:0]            oaddr_q, oaddr_d;
  logic signed [32:0]    oraw_q, oraw_d;

  logic                  in_ready;
  logic                  in_acc;
  logic                  out_adv;
  logic [2:0]            eff_len;
  logic [2:0]            shamt;
  logic [31:0]           shifted;
  logic signed [32:0]    raw_ok;
  logic [TickBits-1:0]   el_inc;
  logic                  over_now;
  logic                  over_inc;
  logic                  verdict_fire;
  logic [7:0]            rxb;
  logic [7:0]            want;

  localparam logic [TickBits-1:0] TickMax = '1;

  assign in_ready     = !burst_q && (!ovalid_q || out_o.ready);
  assign in_i.ready   = in_ready;
  assign in_acc       = in_i.valid && in_ready;
  assign out_adv      = ovalid_q && out_o.ready;
  assign rxb          = in_i.rx_byte;

  assign out_o.valid        = ovalid_q;
  assign out_o.result_kind  = okind_q;
  assign out_o.tx_byte      = otx_q;
  assign out_o.tx_last      = olast_q;
  assign out_o.verdict_code = ocode_q;
  assign out_o.read_address = oaddr_q;
  assign out_o.raw_value    = oraw_q;

  always_comb begin
    if (data_length_q == 3'd0) begin
      eff_len = 3'd1;
    end else if (data_length_q > 3'd4) begin
      eff_len = 3'd4;
    end else begin
      eff_len = data_length_q;
    end
  end

  // packing of the captured data bytes
  always_comb begin
    shamt   = (cap_q > eff_len) ? (cap_q - eff_len) : 3'd0;
    shifted = acc_q >> {shamt, 3'b000};
    case (eff_len)
      3'd1:    raw_ok = {{25{value_signed_q & shifted[7]}}, shifted[7:0]};
      3'd2:    raw_ok = {{17{value_signed_q & shifted[15]}}, shifted[15:0]};
      3'd3:    raw_ok = {{9{value_signed_q & shifted[23]}}, shifted[23:0]};
      default: raw_ok = {value_signed_q & shifted[31], shifted[31:0]};
    endcase
  end

  assign el_inc   = (elapsed_q == TickMax) ? elapsed_q : elapsed_q + 1'b1;
  assign over_now = (elapsed_q >= delay_q) || (elapsed_q == TickMax);
  assign over_inc = (el_inc >= delay_q) || (el_inc == TickMax);
  assign want     = (dfpos_q == DfF0) ? HdrDst : HdrSrc;

  always_comb begin
    phase_d   = phase_q;
    elapsed_d = elapsed_q;
    addr_d    = addr_q;
    dfpos_d   = dfpos_q;
    plen_d    = plen_q;
    pcnt_d    = pcnt_q;
    sum_d     = sum_q;
    status_d  = status_q;
    acc_d     = acc_q;
    cap_d     = cap_q;
    pend_d    = pend_q;
    pcode_d   = pcode_q;
    burst_d   = burst_q;
    bidx_d    = bidx_q;
    ovalid_d  = out_adv ? 1'b0 : ovalid_q;
    okind_d   = okind_q;
    otx_d     = otx_q;
    olast_d   = olast_q;
    ocode_d   = ocode_q;
    oaddr_d   = oaddr_q;
    oraw_d    = oraw_q;
    verdict_fire = 1'b0;

    if (burst_q) begin
      if (out_adv) begin
        ovalid_d = 1'b1;
        okind_d  = KindTx;
        ocode_d  = VerdOk;
        oaddr_d  = 8'h00;
        oraw_d   = '0;
        olast_d  = 1'b0;
        if (bidx_q == ReqLastIdx) begin
          otx_d   = ReqSumBase + addr_q;
          olast_d = 1'b1;
          burst_d = 1'b0;
        end else if (bidx_q == ReqAddrIdx) begin
          otx_d = addr_q;
        end else begin
          otx_d = ReqHeader[bidx_q[2:0]];
        end
        bidx_d = bidx_q + 4'd1;
      end
    end else if (in_acc) begin
      case (op_e'(in_i.operation))
        OpStart: begin
          if (phase_q == PhIdle) begin
            ovalid_d  = 1'b1;
            okind_d   = KindTx;
            otx_d     = ReqHeader[0];
            olast_d   = 1'b0;
            ocode_d   = VerdOk;
            oaddr_d   = 8'h00;
            oraw_d    = '0;
            burst_d   = 1'b1;
            bidx_d    = 4'd1;
            addr_d    = in_i.param_address;
            elapsed_d = '0;
            phase_d   = PhWait;
            dfpos_d   = DfHunt;
            plen_d    = '0;
            pcnt_d    = '0;
            sum_d     = '0;
            status_d  = '0;
            acc_d     = '0;
            cap_d     = '0;
            pend_d    = 1'b0;
            pcode_d   = VerdOk;
          end
        end
        OpByte: begin
          if (phase_q == PhWait && !pend_q) begin
            case (dfpos_q)
              DfHunt: begin
                if (rxb == HdrSync) begin
                  sum_d   = HdrSync;
                  dfpos_d = DfF0;
                end
              end
              DfF0, Df10: begin
                if (rxb == want) begin
                  sum_d   = sum_q + rxb;
                  dfpos_d = (dfpos_q == DfF0) ? Df10 : DfLen;
                end else if (rxb == HdrSync) begin
                  sum_d   = HdrSync;
                  dfpos_d = DfF0;
                end else begin
                  sum_d   = '0;
                  dfpos_d = DfHunt;
                end
              end
              DfLen: begin
                plen_d  = rxb;
                pcnt_d  = '0;
                cap_d   = '0;
                acc_d   = '0;
                sum_d   = sum_q + rxb;
                dfpos_d = (rxb == 8'h00) ? DfCks : DfPay;
              end
              DfPay: begin
                if (pcnt_q == 8'h00) begin
                  status_d = rxb;
                end else if (cap_q < 3'd4) begin
                  acc_d = {acc_q[23:0], rxb};
                  cap_d = cap_q + 3'd1;
                end
                pcnt_d = pcnt_q + 8'd1;
                sum_d  = sum_q + rxb;
                if (pcnt_q + 8'd1 == plen_q) begin
                  dfpos_d = DfCks;
                end
              end
              default: begin
                pend_d = 1'b1;
                if (sum_q != rxb) begin
                  pcode_d = VerdChecksum;
                end else if ({1'b0, plen_q} < 9'd1 + {6'd0, eff_len}) begin
                  pcode_d = VerdShort;
                end else if (status_q != StatusOk) begin
                  pcode_d = VerdStatus;
                end else begin
                  pcode_d = VerdOk;
                end
              end
            endcase
            if (pend_d && over_now) begin
              verdict_fire = 1'b1;
            end
          end
        end
        OpTick: begin
          if (phase_q == PhWait) begin
            elapsed_d = el_inc;
            if (over_inc) begin
              if (pend_q) begin
                verdict_fire = 1'b1;
              end else if ((el_inc > timeout_q) || (el_inc == TickMax)) begin
                verdict_fire = 1'b1;
                pcode_d      = VerdTimeout;
              end
            end
          end
        end
        default: begin
        end
      endcase

      if (verdict_fire) begin
        ovalid_d = 1'b1;
        okind_d  = KindVerdict;
        otx_d    = 8'h00;
        olast_d  = 1'b0;
        ocode_d  = pcode_d;
        oaddr_d  = addr_q;
        oraw_d   = (pcode_d == VerdOk) ? raw_ok : '0;
        phase_d  = PhIdle;
        dfpos_d  = DfHunt;
        plen_d   = '0;
        pcnt_d   = '0;
        sum_d    = '0;
        status_d = '0;
        acc_d    = '0;
        cap_d    = '0;
        pend_d   = 1'b0;
        pcode_d  = VerdOk;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_length_q  <= 3'd1;
      value_signed_q <= 1'b0;
      delay_q        <= 16'd50;
      timeout_q      <= 16'd500;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgDataLength:  data_length_q  <= cfg_data_i[2:0];
        CfgValueSigned: value_signed_q <= cfg_data_i[0];
        CfgDelay:       delay_q        <= cfg_data_i;
        CfgTimeout:     timeout_q      <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      elapsed_q <= '0;
      addr_q    <= '0;
      dfpos_q   <= DfHunt;
      plen_q    <= '0;
      pcnt_q    <= '0;
      sum_q     <= '0;
      status_q  <= '0;
      acc_q     <= '0;
      cap_q     <= '0;
      pend_q    <= 1'b0;
      pcode_q   <= VerdOk;
      burst_q   <= 1'b0;
      bidx_q    <= '0;
      ovalid_q  <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      elapsed_q <= elapsed_d;
      addr_q    <= addr_d;
      dfpos_q   <= dfpos_d;
      plen_q    <= plen_d;
      pcnt_q    <= pcnt_d;
      sum_q     <= sum_d;
      status_q  <= status_d;
      acc_q     <= acc_d;
      cap_q     <= cap_d;
      pend_q    <= pend_d;
      pcode_q   <= pcode_d;
      burst_q   <= burst_d;
      bidx_q    <= bidx_d;
      ovalid_q  <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    okind_q <= okind_d;
    otx_q   <= otx_d;
    olast_q <= olast_d;
    ocode_q <= ocode_d;
    oaddr_q <= oaddr_d;
    oraw_q  <= oraw_d;
  end

  // request run only while waiting for the answer
  a_burst_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    burst_q |-> (phase_q == PhWait))
    else $error("request run outside wait phase");

  a_burst_tx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (burst_q && ovalid_q) |-> (okind_q == KindTx && !olast_q))
    else $error("non-transmit result inside request run");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (burst_q && out_adv && bidx_q == ReqLastIdx) |=> (!burst_q && olast_q && ovalid_q))
    else $error("checksum byte did not end request run");

  a_verdict_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && verdict_fire) |=> (phase_q == PhIdle && !pend_q && okind_q == KindVerdict))
    else $error("verdict left engine busy");

  a_no_take_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    burst_q |-> !in_i.ready)
    else $error("input taken during request run");

endmodule

`default_nettype wire

>>> bench/kdr_read_checker.sv
// Scoreboard for the K-line diagnostic read engine: watches the item, result and register ports.
// Keeps its own model of the engine and compares every result transaction in order.
// Depends on kdr_pkg and the channel interfaces in kdr_if.sv.
`timescale 1ns / 1ps
`default_nettype none

module kdr_read_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  kdr_in_if           in_mon,
  kdr_out_if          out_mon,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output int          fail_count_o,
  output int          awaited_o,
  output int          verdicts_o,
  output int          checked_o,
  output logic        busy_o
);
  import kdr_pkg::*;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic [2:0]  code;
    logic [7:0]  addr;
    logic [32:0] raw;
  } engine_result_t;

  localparam logic [7:0] RequestHead [8] = '{
    8'h80, 8'h10, 8'hF0, 8'h05, 8'hA8, 8'h00, 8'h00, 8'h00
  };

  engine_result_t awaited_results[$];
  engine_result_t oldest;

  // register copy
  logic [2:0]  cfg_len;
  logic        cfg_signed;
  logic [15:0] cfg_delay;
  logic [15:0] cfg_timeout;

  // engine state
  phase_e      phase_q;
  logic [15:0] elapsed_q;
  logic [7:0]  addr_q;
  dfpos_e      dpos_q;
  logic [7:0]  plen_q;
  logic [7:0]  pcount_q;
  logic [7:0]  rsum_q;
  logic [7:0]  status_q;
  logic [31:0] acc_q;
  int          captured_q;
  logic        held_q;
  verdict_e    held_code_q;

  assign busy_o = (phase_q == PhWait);

  function automatic int data_bytes();
    if (cfg_len < 3'd1) return 1;
    if (cfg_len > 3'd4) return 4;
    return int'(cfg_len);
  endfunction

  function automatic logic delay_over();
    return (elapsed_q >= cfg_delay) || (elapsed_q == 16'hFFFF);
  endfunction

  task automatic push_result(kind_e kind, logic [7:0] tx, logic last, logic [2:0] code,
                             logic [7:0] addr, logic [32:0] raw);
    engine_result_t r;
    r.kind = kind;
    r.tx_byte = tx;
    r.tx_last = last;
    r.code = code;
    r.addr = addr;
    r.raw = raw;
    awaited_results = {awaited_results, r};
  endtask

  task automatic clear_frame();
    dpos_q = DfHunt;
    plen_q = '0;
    pcount_q = '0;
    rsum_q = '0;
    status_q = '0;
    acc_q = '0;
    captured_q = 0;
    held_q = 1'b0;
    held_code_q = VerdOk;
  endtask

  task automatic finish_read(verdict_e code);
    logic [63:0] v;
    logic [63:0] mask;
    int dl;
    int sh;
    v = '0;
    if (code == VerdOk) begin
      dl = data_bytes();
      sh = (captured_q > dl) ? 8 * (captured_q - dl) : 0;
      mask = (64'd1 << (8 * dl)) - 64'd1;
      v = ({32'd0, acc_q} >> sh) & mask;
      if (cfg_signed && v[8 * dl - 1]) v = v | ~mask;
    end
    push_result(KindVerdict, 8'h00, 1'b0, code, addr_q, v[32:0]);
    phase_q = PhIdle;
    clear_frame();
  endtask

  task automatic absorb_byte(logic [7:0] b);
    logic [7:0] want;
    case (dpos_q)
      DfHunt: begin
        if (b == 8'h80) begin
          rsum_q = 8'h80;
          dpos_q = DfF0;
        end
      end
      DfF0, Df10: begin
        want = (dpos_q == DfF0) ? 8'hF0 : 8'h10;
        if (b == want) begin
          rsum_q = rsum_q + b;
          dpos_q = (dpos_q == DfF0) ? Df10 : DfLen;
        end else if (b == 8'h80) begin
          rsum_q = 8'h80;
          dpos_q = DfF0;
        end else begin
          rsum_q = '0;
          dpos_q = DfHunt;
        end
      end
      DfLen: begin
        plen_q = b;
        pcount_q = '0;
        captured_q = 0;
        acc_q = '0;
        rsum_q = rsum_q + b;
        dpos_q = (b == 8'h00) ? DfCks : DfPay;
      end
      DfPay: begin
        if (pcount_q == 8'h00) begin
          status_q = b;
        end else if (captured_q < 4) begin
          acc_q = {acc_q[23:0], b};
          captured_q++;
        end
        pcount_q = pcount_q + 8'd1;
        rsum_q = rsum_q + b;
        if (pcount_q == plen_q) dpos_q = DfCks;
      end
      default: begin
        // checksum first, then length, then status
        if (rsum_q != b) held_code_q = VerdChecksum;
        else if (int'(plen_q) < 1 + data_bytes()) held_code_q = VerdShort;
        else if (status_q != 8'hE8) held_code_q = VerdStatus;
        else held_code_q = VerdOk;
        held_q = 1'b1;
      end
    endcase
  endtask

  task automatic step_engine(op_e op, logic [7:0] addr, logic [7:0] b);
    logic [7:0] sum;
    case (op)
      OpStart: begin
        if (phase_q == PhIdle) begin
          sum = '0;
          for (int k = 0; k < 8; k++) begin
            push_result(KindTx, RequestHead[k], 1'b0, 3'd0, 8'h00, 33'd0);
            sum = sum + RequestHead[k];
          end
          push_result(KindTx, addr, 1'b0, 3'd0, 8'h00, 33'd0);
          push_result(KindTx, sum + addr, 1'b1, 3'd0, 8'h00, 33'd0);
          addr_q = addr;
          elapsed_q = '0;
          clear_frame();
          phase_q = PhWait;
        end
      end
      OpByte: begin
        if (phase_q == PhWait && !held_q) begin
          absorb_byte(b);
          if (held_q && delay_over()) finish_read(held_code_q);
        end
      end
      OpTick: begin
        if (phase_q == PhWait) begin
          if (elapsed_q != 16'hFFFF) elapsed_q = elapsed_q + 16'd1;
          if (delay_over()) begin
            if (held_q) finish_read(held_code_q);
            else if (elapsed_q > cfg_timeout || elapsed_q == 16'hFFFF)
              finish_read(VerdTimeout);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(string name, logic [32:0] exp_v, logic [32:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_len = 3'd1;
      cfg_signed = 1'b0;
      cfg_delay = 16'd50;
      cfg_timeout = 16'd500;
      phase_q = PhIdle;
      elapsed_q = '0;
      addr_q = '0;
      clear_frame();
      awaited_results.delete();
      fail_count_o = 0;
      verdicts_o = 0;
      checked_o = 0;
      awaited_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CfgDataLength:  cfg_len = cfg_data_i[2:0];
          CfgValueSigned: cfg_signed = cfg_data_i[0];
          CfgDelay:       cfg_delay = cfg_data_i;
          default:        cfg_timeout = cfg_data_i;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got kind %0d tx %0h code %0d",
                   $time, out_mon.result_kind, out_mon.tx_byte, out_mon.verdict_code);
          fail_count_o++;
        end else begin
          oldest = awaited_results.pop_front();
          check_field("result_kind", 33'(oldest.kind), 33'(out_mon.result_kind));
          check_field("tx_byte", 33'(oldest.tx_byte), 33'(out_mon.tx_byte));
          check_field("tx_last", 33'(oldest.tx_last), 33'(out_mon.tx_last));
          check_field("verdict_code", 33'(oldest.code), 33'(out_mon.verdict_code));
          check_field("read_address", 33'(oldest.addr), 33'(out_mon.read_address));
          check_field("raw_value", oldest.raw, out_mon.raw_value);
          checked_o++;
          if (oldest.kind == KindVerdict) verdicts_o++;
        end
      end
      if (in_mon.valid && in_mon.ready)
        step_engine(op_e'(in_mon.operation), in_mon.param_address, in_mon.rx_byte);
      awaited_o = awaited_results.size();
    end
  end

endmodule

`default_nettype wire

>>> bench/testbench.sv
// Top of the read engine bench: clock, reset, item and register stimulus, result-side stalls.
// Directed frames and random read sequences under four pressure modes.
// Depends on kdr_pkg, kdr_if.sv, kline_diag_read_engine_unit and kdr_read_checker.
`timescale 1ns / 1ps
`default_nettype none

module testbench;
  import kdr_pkg::*;

  localparam logic [7:0] OpeningBytes [15] = '{
    8'h80, 8'h80, 8'hF0, 8'h55, 8'h80, 8'hF0, 8'h10, 8'h05,
    8'hE8, 8'h80, 8'h00, 8'h00, 8'h01, 8'hEE, 8'h33
  };
  localparam int IdlePct  [4] = '{0, 54, 0, 27};
  localparam int StallPct [4] = '{0, 0, 54, 27};

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  int   fail_count;
  int   awaited;
  int   verdicts;
  int   checked;
  logic engine_busy;

  int idle_pct;
  int stall_pct;
  int items_sent;
  int cur_dlen;

  kdr_in_if  item_ch ();
  kdr_out_if result_ch ();

  kline_diag_read_engine_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (item_ch),
    .out_o       (result_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  kdr_read_checker scoreboard (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (item_ch),
    .out_mon      (result_ch),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .awaited_o    (awaited),
    .verdicts_o   (verdicts),
    .checked_o    (checked),
    .busy_o       (engine_busy)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      result_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    #(6_000_000);
    $display("Verification failed");
    $finish;
  end

  // entered and left at a falling edge; valid stays high after a transaction
  task automatic send(op_e op, logic [7:0] addr, logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      item_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    item_ch.valid <= 1'b1;
    item_ch.operation <= op;
    item_ch.param_address <= addr;
    item_ch.rx_byte <= b;
    @(posedge clk_i);
    while (!item_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    if (op != OpRsvd) items_sent++;
  endtask

  task automatic tick();
    send(OpTick, 8'($urandom), 8'($urandom));
  endtask

  // a received byte, sometimes preceded by a tick, a stray start or a reserved op
  task automatic stream_byte(logic [7:0] b);
    int r;
    r = $urandom_range(99);
    if (r < 8) tick();
    else if (r < 10) send(OpStart, 8'($urandom), 8'($urandom));
    else if (r < 12) send(OpRsvd, 8'($urandom), 8'($urandom));
    send(OpByte, 8'($urandom), b);
  endtask

  task automatic send_frame(logic [7:0] len, logic [7:0] status, logic good_cks);
    logic [7:0] sum;
    logic [7:0] b;
    sum = HdrSync + HdrDst + HdrSrc + len;
    stream_byte(HdrSync);
    stream_byte(HdrDst);
    stream_byte(HdrSrc);
    stream_byte(len);
    for (int i = 0; i < int'(len); i++) begin
      b = (i == 0) ? status : 8'($urandom);
      sum = sum + b;
      stream_byte(b);
    end
    stream_byte(good_cks ? sum : sum ^ 8'($urandom_range(255, 1)));
  endtask

  task automatic drain_read();
    while (engine_busy) tick();
  endtask

  task automatic settle();
    item_ch.valid <= 1'b0;
    while (awaited != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic program_register(cfg_idx_e idx, logic [15:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic apply_settings(int dl, int sg, int dly, int tmo);
    settle();
    program_register(CfgDataLength, 16'(dl));
    program_register(CfgValueSigned, 16'(sg));
    program_register(CfgDelay, 16'(dly));
    program_register(CfgTimeout, 16'(tmo));
    cur_dlen = (dl < 1) ? 1 : (dl > 4) ? 4 : dl;
  endtask

  task automatic read_sequence();
    int r;
    int n;
    int len;
    logic [7:0] status;
    r = $urandom_range(99);
    send(OpStart, 8'($urandom), 8'($urandom));
    if (r >= 8) begin
      if ($urandom_range(99) < 25) repeat ($urandom_range(3, 1)) stream_byte(8'($urandom));
      if ($urandom_range(99) < 15) begin
        stream_byte(HdrSync);
        stream_byte(8'($urandom));
      end
      n = $urandom_range(99);
      if (n < 65) len = $urandom_range(6, cur_dlen + 1);
      else if (n < 82) len = $urandom_range(cur_dlen, 0);
      else if (n < 97) len = $urandom_range(12, 0);
      else len = $urandom_range(255, 13);
      status = ($urandom_range(99) < 85) ? StatusOk : 8'($urandom);
      send_frame(8'(len), status, $urandom_range(99) < 85);
      if ($urandom_range(99) < 20) repeat ($urandom_range(2, 1)) stream_byte(8'($urandom));
    end
    drain_read();
  endtask

  initial begin
    item_ch.valid = 1'b0;
    item_ch.operation = OpStart;
    item_ch.param_address = '0;
    item_ch.rx_byte = '0;
    cfg_we_i = 1'b0;
    cfg_index_i = CfgDataLength;
    cfg_data_i = '0;
    rst_ni = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    items_sent = 0;
    cur_dlen = 1;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: idle noise, ignored start, broken headers, signed four-byte read, timeout
    apply_settings(4, 1, 2, 6);
    send(OpByte, 8'h00, HdrSync);
    send(OpTick, 8'hFF, 8'hFF);
    send(OpRsvd, 8'hFF, 8'hFF);
    send(OpStart, 8'hFF, 8'h00);
    send(OpStart, 8'h00, 8'hFF);
    foreach (OpeningBytes[i]) send(OpByte, 8'h00, OpeningBytes[i]);
    tick();
    tick();
    send(OpStart, 8'h00, 8'h00);
    drain_read();

    // random reads, two register settings per pressure mode
    for (int seg = 0; seg < 8; seg++) begin
      case (seg)
        0: apply_settings(4, 1, 0, 24);
        1: apply_settings(1, 0, 8, 40);
        2: apply_settings(0, 1, 3, 15);
        3: apply_settings(7, 0, 1, 30);
        4: apply_settings(2, 1, 0, 0);
        default: apply_settings($urandom_range(7, 0), $urandom_range(1, 0),
                                $urandom_range(8, 0), $urandom_range(40, 0));
      endcase
      idle_pct = IdlePct[seg >> 1];
      stall_pct = StallPct[seg >> 1];
      while (items_sent < 30 + 50 * (seg + 1))
        read_sequence();
    end

    settle();
    repeat (10) @(negedge clk_i);
    $display("Run covered %0d input transactions, %0d results checked, %0d read verdicts.",
             items_sent, checked, verdicts);
    $display("Four pressure modes, data lengths 0 to 7, signed and unsigned, timeouts.");
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
